// ===== hw/rtl/utf8s_pkg.sv =====
// Shared types, constants and byte classification for the UTF-8 byte sanitiser.
`default_nettype none
package utf8s_pkg;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CODE_CONT  = 8'h80;

  // U+FFFD as UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam int unsigned NUM_SYM   = 4;
  localparam int unsigned NUM_HELD  = 3;

  // one symbol of a run: a literal byte or a replacement (three bytes)
  typedef struct packed {
    logic       rep;
    logic [7:0] lit;
  } sym_t;

  // all result bytes caused by one item
  typedef struct packed {
    sym_t [NUM_SYM-1:0] sym;
    logic [1:0]         last;   // index of the final symbol
    logic               eos;
  } run_t;

  typedef struct packed {
    logic [1:0] cnt;   // bytes held
    logic [2:0] slen;  // length announced by the held lead
  } hold_t;

  typedef logic [NUM_HELD-1:0][7:0] held_t;

  // 1 = ASCII, 2..4 = multi-byte lead, 0 = cannot lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b <= ASCII_MAX)                     len = 3'd1;
    else if ((b & MASK_LEAD2) == CODE_LEAD2) len = 3'd2;
    else if ((b & MASK_LEAD3) == CODE_LEAD3) len = 3'd3;
    else if ((b & MASK_LEAD4) == CODE_LEAD4) len = 3'd4;
    else                                     len = 3'd0;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & MASK_CONT) == CODE_CONT;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/utf8s_decode.sv =====
// Per-item decode: next hold state and the run of result symbols.
`default_nettype none
module utf8s_decode
  import utf8s_pkg::*;
(
  input  wire logic [7:0] byte_i,
  input  wire logic       eos_i,
  input  wire hold_t      hold_i,
  input  wire held_t      held_i,
  output hold_t           hold_o,
  output held_t           held_o,
  output run_t            run_o,
  output logic            load_o
);

  logic [2:0] len;
  logic [2:0] cnt_inc;
  logic       cont;

  always_comb begin
    len     = lead_len(byte_i);
    cont    = is_cont(byte_i);
    cnt_inc = {1'b0, hold_i.cnt} + 3'd1;
    hold_o  = hold_i;
    held_o  = held_i;
    run_o   = '0;
    run_o.eos = eos_i;
    load_o  = 1'b0;

    if (hold_i.cnt != 2'd0 && cont) begin
      if (cnt_inc >= hold_i.slen) begin
        // sequence complete: held bytes then this one
        for (int i = 0; i < NUM_HELD; i++) begin
          if (3'(i) < {1'b0, hold_i.cnt}) begin
            run_o.sym[i].lit = held_i[i];
          end
        end
        run_o.sym[hold_i.cnt].lit = byte_i;
        run_o.last = hold_i.cnt;
        load_o     = 1'b1;
        hold_o     = '0;
      end else begin
        if (hold_i.cnt != 2'd3) begin
          held_o[hold_i.cnt] = byte_i;
        end
        hold_o.cnt = cnt_inc[1:0];
        if (eos_i) begin
          // cut short by end of string
          for (int i = 0; i < NUM_SYM; i++) begin
            run_o.sym[i].rep = (3'(i) < cnt_inc);
          end
          run_o.last = hold_i.cnt;
          load_o     = 1'b1;
          hold_o     = '0;
        end
      end
    end else begin
      // flush whatever is held, then treat this byte as a lead
      for (int i = 0; i < NUM_SYM; i++) begin
        run_o.sym[i].rep = (3'(i) < {1'b0, hold_i.cnt});
      end
      hold_o = '0;
      if (len == 3'd1) begin
        run_o.sym[hold_i.cnt].lit = byte_i;
        run_o.last = hold_i.cnt;
        load_o     = 1'b1;
      end else if (len == 3'd0 || eos_i) begin
        run_o.sym[hold_i.cnt].rep = 1'b1;
        run_o.last = hold_i.cnt;
        load_o     = 1'b1;
      end else begin
        held_o[0]   = byte_i;
        hold_o.cnt  = 2'd1;
        hold_o.slen = len;
        if (hold_i.cnt != 2'd0) begin
          run_o.last = hold_i.cnt - 2'd1;
          load_o     = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_byte_sanitizer.sv =====
// Top level of the UTF-8 byte sanitiser: hold state, run register and output sequencer.
// Streams bytes through, passing well-formed UTF-8 unchanged and replacing each byte that
// cannot lead or complete a sequence by EF BF BD (U+FFFD). A multi-byte sequence is held
// until complete; if a non-continuation byte or the end of the string breaks it, the lead
// and each held continuation each become EF BF BD and the breaking byte is taken as a new
// lead. Overlong forms and surrogates are not checked. Every item is decoded in the cycle
// it is accepted, and its result bytes are parked in a run register that feeds the output
// one byte per cycle while out_ready is high. Plain ASCII and held leads/continuations
// flow at one item per cycle while the output does not stall; an item yielding several
// bytes (up to 12) holds the output port until its last byte is taken, and the next item
// is accepted in the cycle that byte is taken. out_run_last marks the last byte of an
// item's run, out_string_done the last byte of a string. No clearing pass after reset.
`default_nettype none
module utf8_byte_sanitizer
  import utf8s_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_done
);

  // hold state: bytes of an unfinished sequence
  hold_t hold_r, hold_nxt;
  held_t held_r, held_nxt;

  // run register and read pointer
  run_t       run_r, run_nxt, run_dec;
  logic       run_valid_r, run_valid_nxt;
  logic [1:0] sym_idx_r, sym_idx_nxt;
  logic [1:0] sub_r, sub_nxt;      // byte within a replacement
  logic       load;

  sym_t cur_sym;
  logic last_of_sym, last_of_run;
  logic fire_in, fire_out, run_done;

  utf8s_decode u_dec (
    .byte_i (in_byte),
    .eos_i  (in_end_of_string),
    .hold_i (hold_r),
    .held_i (held_r),
    .hold_o (hold_nxt),
    .held_o (held_nxt),
    .run_o  (run_dec),
    .load_o (load)
  );

  // --- output side ---
  always_comb begin
    cur_sym     = run_r.sym[sym_idx_r];
    last_of_sym = !cur_sym.rep || (sub_r == 2'd2);
    last_of_run = last_of_sym && (sym_idx_r == run_r.last);
    case (sub_r)
      2'd0:    out_byte = cur_sym.rep ? REPL_B0 : cur_sym.lit;
      2'd1:    out_byte = REPL_B1;
      default: out_byte = REPL_B2;
    endcase
  end

  assign out_valid       = run_valid_r;
  assign out_run_last    = last_of_run;
  assign out_string_done = last_of_run && run_r.eos;

  assign fire_out = out_valid && out_ready;
  assign run_done = fire_out && last_of_run;
  // next item may enter as the current run's last byte leaves
  assign in_ready = !run_valid_r || run_done;
  assign fire_in  = in_valid && in_ready;

  // --- sequencer next state ---
  always_comb begin
    run_nxt       = run_r;
    run_valid_nxt = run_valid_r;
    sym_idx_nxt   = sym_idx_r;
    sub_nxt       = sub_r;
    if (fire_in && load) begin
      run_nxt       = run_dec;
      run_valid_nxt = 1'b1;
      sym_idx_nxt   = 2'd0;
      sub_nxt       = 2'd0;
    end else if (run_done) begin
      run_valid_nxt = 1'b0;
    end else if (fire_out) begin
      if (last_of_sym) begin
        sym_idx_nxt = sym_idx_r + 2'd1;
        sub_nxt     = 2'd0;
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= '0;
      run_valid_r <= 1'b0;
      sym_idx_r   <= 2'd0;
      sub_r       <= 2'd0;
    end else begin
      if (fire_in) begin
        hold_r <= hold_nxt;
      end
      run_valid_r <= run_valid_nxt;
      sym_idx_r   <= sym_idx_nxt;
      sub_r       <= sub_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (fire_in) begin
      held_r <= held_nxt;
    end
    run_r <= run_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8s_checker.sv =====
// Port-level checks for the UTF-8 byte sanitiser, bound to the top level.
`default_nettype none
module utf8s_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last,
  input wire logic       out_string_done
);

  // a stalled result byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_run_last) && $stable(out_string_done))
    else $error("result item changed while stalled");

  // end of string always closes an item's run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_done |-> out_run_last)
    else $error("string_done without run_last");

  // input back-pressure only while a run is pending
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // reset empties the run register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind utf8_byte_sanitizer utf8s_checker u_chk (.*);
`default_nettype wire

// ===== sim/utf8_stream_checker.sv =====
// Checker for the UTF-8 byte sanitiser: predicts the sanitised byte stream and compares it.
`timescale 1ns / 1ps
module utf8_stream_checker
  import utf8s_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_string,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_byte,
  input  logic              out_run_last,
  input  logic              out_string_done,
  output int unsigned       fail_count,
  output int unsigned       expected_left,
  output int unsigned       bytes_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       done;
  } sanitized_t;

  sanitized_t  sanitized_q[$];
  logic [7:0]  held [3];
  logic [1:0]  held_n;
  logic [2:0]  want_len;
  int unsigned err_n;
  int unsigned seen_n;

  // sequence length a byte announces at lead position, 0 if it cannot lead
  function automatic logic [2:0] utf8_len(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    sanitized_t item;
    item.data     = b;
    item.run_last = 1'b0;
    item.done     = 1'b0;
    sanitized_q.insert(sanitized_q.size(), item);
  endtask

  task automatic emit_fffd();
    emit_byte(REPL_B0);
    emit_byte(REPL_B1);
    emit_byte(REPL_B2);
  endtask

  // broken sequence: lead and each held continuation become U+FFFD
  task automatic drop_held();
    int i;
    for (i = 0; i < int'(held_n); i++) emit_fffd();
    held_n   = '0;
    want_len = '0;
  endtask

  task automatic start_seq(input logic [7:0] b, input logic eos);
    logic [2:0] len;
    len = utf8_len(b);
    if (len == 3'd1) begin
      emit_byte(b);
    end else if (len == 3'd0 || eos) begin
      emit_fffd();
    end else begin
      held[0]  = b;
      held_n   = 2'd1;
      want_len = len;
    end
  endtask

  task automatic sanitize_byte(input logic [7:0] b, input logic eos);
    int         first;
    int         i;
    sanitized_t tail;
    first = sanitized_q.size();
    if (held_n == 2'd0) begin
      start_seq(b, eos);
    end else if (b[7:6] == 2'b10) begin
      if (int'(held_n) + 1 >= int'(want_len)) begin
        for (i = 0; i < int'(held_n); i++) emit_byte(held[i]);
        emit_byte(b);
        held_n   = '0;
        want_len = '0;
      end else begin
        held[held_n] = b;
        held_n       = held_n + 2'd1;
        if (eos) drop_held();
      end
    end else begin
      drop_held();
      start_seq(b, eos);
    end
    if (sanitized_q.size() > first) begin
      tail          = sanitized_q.pop_back();
      tail.run_last = 1'b1;
      tail.done     = eos;
      sanitized_q.insert(sanitized_q.size(), tail);
    end
  endtask

  task automatic check_output();
    sanitized_t want;
    seen_n++;
    if (sanitized_q.size() == 0) begin
      $error("out_byte: no byte expected, got %02h", out_byte);
      err_n++;
    end else begin
      want = sanitized_q.pop_front();
      if (out_byte !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
        err_n++;
      end
      if (out_run_last !== want.run_last) begin
        $error("out_run_last: expected %0b, got %0b", want.run_last, out_run_last);
        err_n++;
      end
      if (out_string_done !== want.done) begin
        $error("out_string_done: expected %0b, got %0b", want.done, out_string_done);
        err_n++;
      end
    end
  endtask

  // input taken first: a byte leaving at the same edge belongs to an older item
  always @(posedge clk) begin
    if (!rst_n) begin
      sanitized_q.delete();
      held_n   = '0;
      want_len = '0;
    end else begin
      if (in_valid && in_ready) sanitize_byte(in_byte, in_end_of_string);
      if (out_valid && out_ready) check_output();
    end
    fail_count    <= err_n;
    expected_left <= sanitized_q.size();
    bytes_checked <= seen_n;
  end

endmodule

// ===== sim/utf8_byte_sanitizer_tb.sv =====
// Testbench top for the UTF-8 byte sanitiser: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module utf8_byte_sanitizer_tb;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte          = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_done;

  // hold_req: sender asks the receiver for one long hold-off
  // burst_mode: neither side idles
  logic hold_req   = 1'b0;
  logic burst_mode = 1'b0;

  int unsigned fail_count;
  int unsigned expected_left;
  int unsigned bytes_checked;
  int unsigned items_sent   = 0;
  int unsigned strings_sent = 0;
  logic [7:0]  str_q[$];

  always #5 clk = ~clk;

  utf8_byte_sanitizer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_string_done  (out_string_done)
  );

  utf8_stream_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_string_done  (out_string_done),
    .fail_count       (fail_count),
    .expected_left    (expected_left),
    .bytes_checked    (bytes_checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_lead(input int len);
    case (len)
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // One item: optional idle gap, then valid held with a stable payload until taken.
  // valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic offer_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = (burst_mode || $urandom_range(0, 2) != 0) ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // sends str_q as one string, end flag on the final byte
  task automatic send_string();
    int i;
    for (i = 0; i < str_q.size(); i++) offer_byte(str_q[i], i == str_q.size() - 1);
    strings_sent++;
  endtask

  // Mostly well-formed sequences with random content; the rest stray bytes and
  // sequences cut short, broken by the next chunk or by the end of the string.
  task automatic build_string();
    int chunks;
    int k;
    int r;
    int len;
    int j;
    str_q.delete();
    chunks = $urandom_range(1, 6);
    for (k = 0; k < chunks; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        str_q.insert(str_q.size(), 8'($urandom_range(0, 127)));
      end else if (r < 70) begin
        len = $urandom_range(2, 4);
        str_q.insert(str_q.size(), rand_lead(len));
        for (j = 1; j < len; j++) str_q.insert(str_q.size(), rand_cont());
      end else if (r < 85) begin
        len = $urandom_range(2, 4);
        str_q.insert(str_q.size(), rand_lead(len));
        for (j = $urandom_range(0, len - 2); j > 0; j--) str_q.insert(str_q.size(), rand_cont());
      end else begin
        str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: random stalls, none in burst mode, and one long hold-off on request
  // so the run register fills and in_ready drops while the sender keeps offering.
  initial begin
    int stall;
    int hold_left;
    bit hold_taken;
    stall      = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = 80;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (burst_mode) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
        out_ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ASCII extremes
    str_q = '{8'h00, 8'h7F};
    send_string();
    // stray continuations and bytes that can never lead
    str_q = '{8'h80, 8'hBF, 8'hF8, 8'hFF};
    send_string();
    // overlong C0 form and a surrogate both pass untouched
    str_q = '{8'hC0, 8'hAF, 8'hED, 8'hA0, 8'h80};
    send_string();
    // complete 4-byte sequence, finished by the end-of-string byte
    str_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    // lead arriving with the end flag cannot finish
    str_q = '{8'hC3};
    send_string();
    // 3-byte sequence broken by ASCII
    str_q = '{8'hE2, 8'h82, 8'h41};
    send_string();
    // three held bytes broken by an invalid lead: the longest run of an item
    str_q = '{8'hF0, 8'h9F, 8'h98, 8'hF8};
    send_string();
    // held sequence cut by the end of the string on a continuation
    str_q = '{8'hF0, 8'h9F};
    send_string();
    // lead broken by a fresh lead that then completes
    str_q = '{8'hC3, 8'hC3, 8'hA9};
    send_string();

    while (items_sent < 530) begin
      burst_mode <= (items_sent >= 150 && items_sent < 260);
      if (!hold_done && items_sent >= 180) begin
        hold_req  <= 1'b1;
        hold_done = 1'b1;
      end
      // sender stands back until every expected byte is out
      if (!pause_done && items_sent >= 350) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
        pause_done = 1'b1;
      end
      build_string();
      send_string();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (expected_left != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d bytes in %0d strings: well-formed 1-4 byte sequences, stray and",
             items_sent, strings_sent);
    $display("invalid bytes, broken and truncated sequences; %0d output bytes compared.",
             bytes_checked);
    if (fail_count == 0 && expected_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
